// ===== src/gfla_pkg.sv =====
// Shared types and constants for the lock arbiter.
`default_nettype none
package gfla_pkg;
    localparam logic [2:0] REQ_SEED    = 3'd0;
    localparam logic [2:0] REQ_CREATE  = 3'd1;
    localparam logic [2:0] REQ_DESTROY = 3'd2;
    localparam logic [2:0] REQ_ACQUIRE = 3'd3;
    localparam logic [2:0] REQ_RELEASE = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_ARG  = 3'd1;
    localparam logic [2:0] ST_NO_FREE  = 3'd2;
    localparam logic [2:0] ST_INACTIVE = 3'd3;
    localparam logic [2:0] ST_NOT_OWN  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;
    localparam logic [6:0]  PCT_MOD = 7'd100;
    localparam logic [6:0]  FAVOR_MAX = 7'd100;
    // floor(x / 100) = (x * PCT_RECIP) >> 37 for every 32-bit x
    localparam logic [31:0] PCT_RECIP = 32'h51EB_851F;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  lock_index;
        logic [5:0]  requester_id;
        logic [7:0]  group_id;
        logic [6:0]  favor_percent;
        logic [31:0] seed_value;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] created_index;
        logic       grant_valid;
        logic [3:0] grant_lock;
        logic [5:0] grant_requester;
    } rsp_t;
endpackage
`default_nettype wire

// ===== src/gfla_front.sv =====
// Front end: request queue that decouples the input port from the engine.
`default_nettype none
module gfla_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire gfla_pkg::req_t  in_word,
    output logic                 req_valid,
    input  wire logic            req_take,
    output gfla_pkg::req_t       req_word
);
    import gfla_pkg::*;

    req_t       slot_reg [2];
    logic [1:0] count_reg;
    logic       wr_reg;
    logic       rd_reg;

    assign full      = (count_reg == 2'd2);
    assign req_valid = (count_reg != 2'd0);
    assign req_word  = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_reg] <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= ~wr_reg;
            end
            if (req_take && req_valid)
            begin
                rd_reg <= ~rd_reg;
            end
            count_reg <= count_reg + 2'((push && !full) ? 1 : 0)
                                   - 2'((req_take && req_valid) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

// ===== src/gfla_back.sv =====
// Back end: lock table, waiter memory and the release scan/rotate sequencer.
`default_nettype none
module gfla_back
#(
    parameter int NUM_LOCKS   = 15,
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_take,
    input  wire gfla_pkg::req_t  req_word,
    output logic                 rsp_valid,
    input  wire logic            rsp_take,
    output gfla_pkg::rsp_t       rsp_word
);
    import gfla_pkg::*;

    localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MD = NUM_LOCKS * QUEUE_DEPTH;
    localparam int AW = $clog2(MD);

    typedef enum logic [3:0] {
        S_IDLE, S_GRANT_RD, S_GRANT_WB, S_SCAN_RD, S_SCAN_CHK, S_MUL,
        S_MOD, S_CMP, S_ROT_RD, S_ROT_WB, S_DONE
    } state_t;

    state_t state_reg;

    logic [NUM_LOCKS-1:0] active_reg, held_reg;
    logic [6:0]  favor_reg [NUM_LOCKS];
    logic [5:0]  owner_reg [NUM_LOCKS];
    logic [QW-1:0] head_reg [NUM_LOCKS];
    logic [QW-1:0] tail_reg [NUM_LOCKS];
    logic [CW-1:0] qcnt_reg [NUM_LOCKS];
    logic [31:0] lcg_reg;

    // waiter memory: {requester, group}
    logic [13:0] mem [MD];
    logic [13:0] rdata_reg;
    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [13:0] mem_wd;

    req_t        cur_reg;
    logic [LW-1:0] lk_reg;
    logic [CW-1:0] i_reg;
    logic [QW-1:0] pos_reg;
    logic [13:0] fav_word_reg;
    logic [31:0] draw_reg;
    logic [63:0] prod_reg;
    logic [31:0] rem_full;
    logic [6:0]  draw_rem;
    logic [2:0]  status_reg;
    logic [3:0]  cidx_reg;
    rsp_t        out_reg;
    logic        out_valid_reg;
    logic        grant_ok_reg;

    function automatic logic [AW-1:0] addr(input logic [LW-1:0] k, input logic [QW-1:0] p);
        logic [AW+LW-1:0] a;
        begin
            a = (AW+LW)'(k) * (AW+LW)'(QUEUE_DEPTH) + (AW+LW)'(p);
            return a[AW-1:0];
        end
    endfunction

    function automatic logic [QW-1:0] qinc(input logic [QW-1:0] p);
        begin
            return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + QW'(1);
        end
    endfunction

    function automatic logic [QW-1:0] qdec(input logic [QW-1:0] p);
        begin
            return (p == '0) ? QW'(QUEUE_DEPTH - 1) : p - QW'(1);
        end
    endfunction

    logic [QW-1:0] scan_p;
    logic [LW:0]   free_idx;
    logic          free_found;

    always_comb
    begin
        logic [QW+CW:0] s;
        s = (QW+CW+1)'(head_reg[lk_reg]) + (QW+CW+1)'(i_reg);
        if (s >= (QW+CW+1)'(QUEUE_DEPTH))
        begin
            s = s - (QW+CW+1)'(QUEUE_DEPTH);
        end
        scan_p = s[QW-1:0];
    end

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int j = NUM_LOCKS - 1; j >= 0; j--)
        begin
            if (!active_reg[j])
            begin
                free_found = 1'b1;
                free_idx   = (LW+1)'(j);
            end
        end
    end

    // draw mod 100 from the registered reciprocal product
    assign rem_full = draw_reg - 32'(prod_reg[63:37]) * 32'(PCT_MOD);
    assign draw_rem = rem_full[6:0];

    assign req_take  = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[mem_ra];
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr(lk_reg, tail_reg[lk_reg]);
        mem_wd = {cur_reg.requester_id, cur_reg.group_id};
        mem_ra = addr(lk_reg, head_reg[lk_reg]);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_take && req_word.req_type == REQ_ACQUIRE
                    && 32'(req_word.lock_index) < NUM_LOCKS
                    && active_reg[LW'(req_word.lock_index)]
                    && 32'(qcnt_reg[LW'(req_word.lock_index)]) < QUEUE_DEPTH)
                begin
                    mem_we = 1'b1;
                    mem_wa = addr(LW'(req_word.lock_index),
                                  tail_reg[LW'(req_word.lock_index)]);
                    mem_wd = {req_word.requester_id, req_word.group_id};
                end
                mem_ra = addr(LW'(req_word.lock_index), '0);
            end
            S_SCAN_RD:  mem_ra = addr(lk_reg, scan_p);
            S_ROT_RD:   mem_ra = addr(lk_reg, qdec(pos_reg));
            S_ROT_WB:
            begin
                mem_we = 1'b1;
                mem_wa = addr(lk_reg, pos_reg);
                mem_wd = (pos_reg == head_reg[lk_reg]) ? fav_word_reg : rdata_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            held_reg      <= '0;
            lcg_reg       <= 32'd1;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < NUM_LOCKS; j++)
            begin
                favor_reg[j] <= '0;
                owner_reg[j] <= '0;
                head_reg[j]  <= '0;
                tail_reg[j]  <= '0;
                qcnt_reg[j]  <= '0;
            end
        end
        else
        begin
            if (rsp_take && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && req_take)
                    begin
                        cur_reg    <= req_word;
                        lk_reg     <= LW'(req_word.lock_index);
                        status_reg <= ST_OK;
                        cidx_reg   <= '0;
                        i_reg      <= '0;
                        state_reg  <= S_DONE;
                        case (req_word.req_type)
                            REQ_SEED: lcg_reg <= req_word.seed_value;
                            REQ_CREATE:
                            begin
                                if (req_word.favor_percent > FAVOR_MAX)
                                begin
                                    status_reg <= ST_BAD_ARG;
                                end
                                else if (!free_found)
                                begin
                                    status_reg <= ST_NO_FREE;
                                end
                                else
                                begin
                                    active_reg[LW'(free_idx)] <= 1'b1;
                                    held_reg[LW'(free_idx)]   <= 1'b0;
                                    favor_reg[LW'(free_idx)]  <= req_word.favor_percent;
                                    owner_reg[LW'(free_idx)]  <= '0;
                                    head_reg[LW'(free_idx)]   <= '0;
                                    tail_reg[LW'(free_idx)]   <= '0;
                                    qcnt_reg[LW'(free_idx)]   <= '0;
                                    cidx_reg <= 4'(free_idx);
                                end
                            end
                            REQ_DESTROY, REQ_ACQUIRE, REQ_RELEASE:
                            begin
                                if (32'(req_word.lock_index) >= NUM_LOCKS)
                                begin
                                    status_reg <= ST_BAD_ARG;
                                end
                                else if (req_word.req_type == REQ_DESTROY)
                                begin
                                    active_reg[LW'(req_word.lock_index)] <= 1'b0;
                                end
                                else if (req_word.req_type == REQ_ACQUIRE)
                                begin
                                    if (!active_reg[LW'(req_word.lock_index)])
                                    begin
                                        status_reg <= ST_INACTIVE;
                                    end
                                    else if (32'(qcnt_reg[LW'(req_word.lock_index)])
                                             >= QUEUE_DEPTH)
                                    begin
                                        status_reg <= ST_FULL;
                                    end
                                    else
                                    begin
                                        tail_reg[LW'(req_word.lock_index)] <=
                                            qinc(tail_reg[LW'(req_word.lock_index)]);
                                        qcnt_reg[LW'(req_word.lock_index)] <=
                                            qcnt_reg[LW'(req_word.lock_index)] + CW'(1);
                                        state_reg <= S_GRANT_RD;
                                    end
                                end
                                else
                                begin
                                    if (!held_reg[LW'(req_word.lock_index)] ||
                                        owner_reg[LW'(req_word.lock_index)]
                                        != req_word.requester_id)
                                    begin
                                        status_reg <= ST_NOT_OWN;
                                    end
                                    else
                                    begin
                                        held_reg[LW'(req_word.lock_index)]  <= 1'b0;
                                        owner_reg[LW'(req_word.lock_index)] <= '0;
                                        state_reg <= S_SCAN_RD;
                                    end
                                end
                            end
                            default: status_reg <= ST_BAD_ARG;
                        endcase
                    end
                end
                S_SCAN_RD:
                begin
                    if (i_reg >= qcnt_reg[lk_reg])
                    begin
                        state_reg <= S_GRANT_RD;
                    end
                    else
                    begin
                        pos_reg   <= scan_p;
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK:
                begin
                    if (rdata_reg[7:0] == cur_reg.group_id)
                    begin
                        fav_word_reg <= rdata_reg;
                        state_reg    <= S_MUL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_MUL:
                begin
                    lcg_reg   <= LCG_MUL * lcg_reg + LCG_ADD;
                    draw_reg  <= LCG_MUL * lcg_reg + LCG_ADD;
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    prod_reg  <= 64'(draw_reg) * 64'(PCT_RECIP);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (draw_rem < favor_reg[lk_reg])
                    begin
                        state_reg <= S_ROT_RD;
                    end
                    else
                    begin
                        state_reg <= S_GRANT_RD;
                    end
                end
                S_ROT_RD:
                begin
                    state_reg <= S_ROT_WB;
                end
                S_ROT_WB:
                begin
                    if (pos_reg == head_reg[lk_reg])
                    begin
                        state_reg <= S_GRANT_RD;
                    end
                    else
                    begin
                        pos_reg   <= qdec(pos_reg);
                        state_reg <= S_ROT_RD;
                    end
                end
                S_GRANT_RD:
                begin
                    state_reg <= S_GRANT_WB;
                end
                S_GRANT_WB:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    out_reg.status          <= status_reg;
                    out_reg.created_index   <= cidx_reg;
                    out_reg.grant_valid     <= grant_ok_reg;
                    out_reg.grant_lock      <= grant_ok_reg ? 4'(lk_reg) : 4'd0;
                    out_reg.grant_requester <= grant_ok_reg ? owner_reg[lk_reg] : 6'd0;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_GRANT_WB && !held_reg[lk_reg] && qcnt_reg[lk_reg] != '0)
            begin
                held_reg[lk_reg]  <= 1'b1;
                owner_reg[lk_reg] <= rdata_reg[13:8];
                head_reg[lk_reg]  <= qinc(head_reg[lk_reg]);
                qcnt_reg[lk_reg]  <= qcnt_reg[lk_reg] - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grant_ok_reg <= 1'b0;
        end
        else if (state_reg == S_IDLE)
        begin
            grant_ok_reg <= 1'b0;
        end
        else if (state_reg == S_GRANT_WB)
        begin
            grant_ok_reg <= !held_reg[lk_reg] && qcnt_reg[lk_reg] != '0;
        end
    end

    // head address read in S_GRANT_RD
    logic unused_ok;
    assign unused_ok = ^{cur_reg.seed_value, cur_reg.favor_percent, cur_reg.req_type,
                         cur_reg.lock_index, mem_ra, rem_full[31:7], prod_reg[36:0]};
endmodule
`default_nettype wire

// ===== src/group_favoring_fifo_lock_arbiter_unit.sv =====
// Top level of the group-favoring lock arbiter.
//  channel | direction | handshake    | word
//  request | in        | push / full  | req_type..seed_value
//  result  | out       | pop / empty  | status..grant_requester
// Seed, create, destroy and failing requests go from S_IDLE to S_DONE; acquire
// first passes S_GRANT_RD and S_GRANT_WB. Release scans the waiter memory entry by
// entry for its group, on a match runs the generator and a reciprocal-multiply
// remainder, rotates that entry to the head if it is below the favor, then grants.
// Reset clears lock table and queues at once; waiter memory needs no clearing.
// A two-word request queue and the result register let each side stall alone;
// the engine takes no new word while its result waits to be popped.
`default_nettype none
module group_favoring_fifo_lock_arbiter_unit
#(
    parameter int NUM_LOCKS   = 15,
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  req_type,
    input  wire logic [4:0]  lock_index,
    input  wire logic [5:0]  requester_id,
    input  wire logic [7:0]  group_id,
    input  wire logic [6:0]  favor_percent,
    input  wire logic [31:0] seed_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       status,
    output logic [3:0]       created_index,
    output logic             grant_valid,
    output logic [3:0]       grant_lock,
    output logic [5:0]       grant_requester
);
    import gfla_pkg::*;

    req_t in_word, req_word;
    rsp_t rsp_word;
    logic req_valid, req_take, rsp_valid;

    assign in_word = '{req_type, lock_index, requester_id, group_id,
                       favor_percent, seed_value};

    gfla_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .req_valid(req_valid), .req_take(req_take), .req_word(req_word)
    );

    gfla_back #(.NUM_LOCKS(NUM_LOCKS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back
    (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_take(req_take),
        .req_word(req_word), .rsp_valid(rsp_valid), .rsp_take(pop),
        .rsp_word(rsp_word)
    );

    assign empty           = !rsp_valid;
    assign status          = rsp_word.status;
    assign created_index   = rsp_word.created_index;
    assign grant_valid     = rsp_word.grant_valid;
    assign grant_lock      = rsp_word.grant_lock;
    assign grant_requester = rsp_word.grant_requester;
endmodule
`default_nettype wire
